// File: sv/assert_macros.svh
// Assertion macros shared by the FFT RTL.
// No dependencies; included by files that check properties.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// File: sv/srfft_pkg.sv
// Package for the Stockham FFT: widths, states, twiddle table, saturation.
// No dependencies.
package srfft_pkg;
  localparam int unsigned MaxPoints = 64;
  localparam int unsigned DataW = 24;
  localparam int unsigned TwW = 16;

  typedef enum logic [2:0] {
    StLoad, StRead, StCalc, StWrite, StEmit
  } state_e;

  typedef logic signed [DataW-1:0] data_t;

  function automatic logic signed [15:0] quarter(input logic [4:0] k);
    case (k)
      5'd0: quarter = 16'sd32767;
      5'd1: quarter = 16'sd32610;
      5'd2: quarter = 16'sd32138;
      5'd3: quarter = 16'sd31357;
      5'd4: quarter = 16'sd30274;
      5'd5: quarter = 16'sd28899;
      5'd6: quarter = 16'sd27246;
      5'd7: quarter = 16'sd25330;
      5'd8: quarter = 16'sd23170;
      5'd9: quarter = 16'sd20788;
      5'd10: quarter = 16'sd18205;
      5'd11: quarter = 16'sd15447;
      5'd12: quarter = 16'sd12540;
      5'd13: quarter = 16'sd9512;
      5'd14: quarter = 16'sd6393;
      5'd15: quarter = 16'sd3212;
      default: quarter = 16'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] twiddle(input logic [4:0] k);
    logic signed [15:0] c;
    logic signed [15:0] s;
    logic signed [15:0] wi;
    c = (k <= 5'd16) ? quarter(k) : -quarter(5'(6'd32 - {1'b0, k}));
    s = (k <= 5'd16) ? quarter(5'(5'd16 - k)) : quarter(5'(k - 5'd16));
    // quarter turn: negative sine is exactly -1.0
    wi = (k == 5'd16) ? 16'sh8000 : -s;
    twiddle = {c, wi};
  endfunction

  function automatic data_t sat(input logic signed [47:0] v);
    if (v > 48'sd8388607) sat = 24'sh7fffff;
    else if (v < -48'sd8388608) sat = 24'sh800000;
    else sat = v[DataW-1:0];
  endfunction
endpackage

// File: sv/stockham_radix2_fft.sv
// Top level of the radix-2 Stockham FFT: sequencer, ping-pong RAMs, butterfly.
// Depends on srfft_pkg, srfft_ram, srfft_bfly and assert_macros.svh.
// Channel | direction | signals
// sample  | in        | sample_valid_i, sample_stall_o, sample_real_i, sample_imag_i
// bin     | out       | bin_valid_o, bin_stall_i, bin_real_o ... last_bin_o
// cfg     | in        | cfg_we_i, cfg_data_i
// Loading takes one sample per cycle. Each butterfly runs on the shared
// multiplier unit as read b, read a and multiply, two writes; after the last
// stage the bins are emitted in index order.
// Reset leaves the buffers unwritten and log_points at six; stall holds the bin.
`include "assert_macros.svh"
module stockham_radix2_fft #(
  parameter int unsigned MaxPoints = srfft_pkg::MaxPoints
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        sample_valid_i,
  output logic        sample_stall_o,
  input  logic signed [15:0] sample_real_i,
  input  logic signed [15:0] sample_imag_i,
  output logic        bin_valid_o,
  input  logic        bin_stall_i,
  output logic signed [23:0] bin_real_o,
  output logic signed [23:0] bin_imag_o,
  output logic [5:0]  bin_index_o,
  output logic        last_bin_o
);
  localparam int unsigned AW = $clog2(MaxPoints);
  localparam int unsigned MaxLog = AW;

  srfft_pkg::state_e state_q, state_d;
  logic [2:0] lp_cfg_q;
  logic [2:0] lg;
  logic [AW:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [2:0] stage_q, stage_d;
  logic src_q, src_d;
  logic phase_q, phase_d;
  logic out_v_q;
  logic [AW-1:0] out_idx_q;
  logic out_last_q;

  logic [AW:0] n;
  logic [AW-1:0] half_n, h, jmask, j, ia, ib, oe, oo;
  logic [4:0] tw_k;
  logic signed [31:0] tw;
  logic [47:0] sum, dif;

  logic we0, we1;
  logic [AW-1:0] wa0, wa1, ra0, ra1, ra;
  logic [47:0] wd0, wd1, rd0, rd1, rd;

  always_comb begin
    if (lp_cfg_q == 3'd0) lg = 3'd1;
    else if (lp_cfg_q > 3'(MaxLog)) lg = 3'(MaxLog);
    else lg = lp_cfg_q;
    n = (AW+1)'(1) << lg;
    half_n = AW'(n >> 1);
    h = AW'(((AW+1)'(1) << stage_q) >> 1);
    jmask = h - AW'(1);
    j = idx_q & jmask;
    ia = idx_q;
    ib = idx_q + half_n;
    oe = ((idx_q & ~jmask) << 1) | j;
    oo = oe + h;
    tw_k = 5'((6'(j) << (3'd6 - stage_q)));
    tw = srfft_pkg::twiddle(tw_k);
    rd = src_q ? rd1 : rd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srfft_pkg::StLoad;
      lp_cfg_q <= 3'd6;
      cnt_q <= '0;
      idx_q <= '0;
      stage_q <= 3'd1;
      src_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (cfg_we_i) lp_cfg_q <= cfg_data_i;
      state_q <= state_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      stage_q <= stage_d;
      src_q <= src_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    stage_d = stage_q;
    src_d = src_q;
    phase_d = phase_q;
    case (state_q)
      srfft_pkg::StLoad: begin
        if (sample_valid_i) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q + 1'b1 >= n) begin
            cnt_d = '0;
            idx_d = '0;
            stage_d = 3'd1;
            src_d = 1'b0;
            state_d = srfft_pkg::StRead;
          end
        end
      end
      srfft_pkg::StRead: state_d = srfft_pkg::StCalc;
      srfft_pkg::StCalc: state_d = srfft_pkg::StWrite;
      srfft_pkg::StWrite: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          state_d = srfft_pkg::StRead;
          if (idx_q == half_n - AW'(1)) begin
            idx_d = '0;
            src_d = ~src_q;
            if (stage_q == lg) begin
              state_d = srfft_pkg::StEmit;
              cnt_d = '0;
            end else stage_d = stage_q + 3'd1;
          end else idx_d = idx_q + AW'(1);
        end
      end
      srfft_pkg::StEmit: begin
        if (!out_v_q || !bin_stall_i) begin
          if (cnt_q == n) state_d = srfft_pkg::StLoad;
          cnt_d = (cnt_q == n) ? '0 : cnt_q + 1'b1;
        end
      end
      default: state_d = srfft_pkg::StLoad;
    endcase
  end

  logic emit_rd;
  assign emit_rd = state_q == srfft_pkg::StEmit && (!out_v_q || !bin_stall_i);
  logic emit_fire;
  assign emit_fire = emit_rd && cnt_q != '0;

  always_comb begin
    we0 = 1'b0;
    we1 = 1'b0;
    wa0 = oe;
    wa1 = oe;
    wd0 = phase_q ? dif : sum;
    wd1 = phase_q ? dif : sum;
    ra = (state_q == srfft_pkg::StRead) ? ib : ia;
    // hold the pending bin while the output is stalled
    if (state_q == srfft_pkg::StEmit)
      ra = emit_rd ? cnt_q[AW-1:0] : cnt_q[AW-1:0] - AW'(1);
    ra0 = ra;
    ra1 = ra;
    case (state_q)
      srfft_pkg::StLoad: begin
        we0 = sample_valid_i;
        wa0 = cnt_q[AW-1:0];
        wd0 = {{8{sample_real_i[15]}}, sample_real_i, {8{sample_imag_i[15]}}, sample_imag_i};
      end
      srfft_pkg::StWrite: begin
        if (src_q) begin
          we0 = 1'b1;
          wa0 = phase_q ? oo : oe;
        end else begin
          we1 = 1'b1;
          wa1 = phase_q ? oo : oe;
        end
      end
      default: ;
    endcase
  end

  srfft_ram #(.Width(48), .Depth(MaxPoints)) u_ping (
    .clk_i, .we_i(we0), .waddr_i(wa0), .wdata_i(wd0), .raddr_i(ra0), .rdata_o(rd0)
  );
  srfft_ram #(.Width(48), .Depth(MaxPoints)) u_pong (
    .clk_i, .we_i(we1), .waddr_i(wa1), .wdata_i(wd1), .raddr_i(ra1), .rdata_o(rd1)
  );

  srfft_bfly u_bfly (
    .clk_i,
    .start_i(state_q == srfft_pkg::StWrite && !phase_q ? 1'b0 :
             state_q == srfft_pkg::StCalc),
    .ar_i(rd[47:24]), .ai_i(rd[23:0]),
    .br_i(rd[47:24]), .bi_i(rd[23:0]),
    .wr_i(tw[31:16]), .wi_i(tw[15:0]),
    .sum_o(sum), .dif_o(dif)
  );

  logic [47:0] out_d_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || !bin_stall_i) begin
      out_v_q <= emit_fire;
    end
  end
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_d_q <= rd;
      out_idx_q <= AW'(cnt_q - 1'b1);
      out_last_q <= cnt_q == n;
    end
  end

  assign sample_stall_o = state_q != srfft_pkg::StLoad;
  assign bin_valid_o = out_v_q;
  assign bin_real_o = out_d_q[47:24];
  assign bin_imag_o = out_d_q[23:0];
  assign bin_index_o = 6'(out_idx_q);
  assign last_bin_o = out_last_q;

  `ASSERT_NEXT(a_hold, clk_i, rst_ni, bin_valid_o && bin_stall_i, bin_valid_o && $stable(bin_index_o))
  `ASSERT_IMPL(a_noload, clk_i, rst_ni, bin_valid_o |-> sample_stall_o || last_bin_o)
endmodule

// File: sv/srfft_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module srfft_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: sv/srfft_bfly.sv
// Shared butterfly unit: one complex multiply with registered products, then a combinational sum/difference.
// Depends on srfft_pkg.
module srfft_bfly (
  input  logic                   clk_i,
  input  logic                   start_i,
  input  srfft_pkg::data_t       ar_i,
  input  srfft_pkg::data_t       ai_i,
  input  srfft_pkg::data_t       br_i,
  input  srfft_pkg::data_t       bi_i,
  input  logic signed [15:0]     wr_i,
  input  logic signed [15:0]     wi_i,
  output logic [47:0]            sum_o,
  output logic [47:0]            dif_o
);
  logic signed [39:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [47:0] zr, zi;
  srfft_pkg::data_t zrs, zis;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p0_q <= 40'(wr_i) * 40'(br_i);
      p1_q <= 40'(wi_i) * 40'(bi_i);
      p2_q <= 40'(wr_i) * 40'(bi_i);
      p3_q <= 40'(wi_i) * 40'(br_i);
    end
  end

  always_comb begin
    zr = (48'(p0_q) - 48'(p1_q) + 48'sd16384) >>> 15;
    zi = (48'(p2_q) + 48'(p3_q) + 48'sd16384) >>> 15;
    zrs = srfft_pkg::sat(zr);
    zis = srfft_pkg::sat(zi);
    sum_o = {srfft_pkg::sat(48'(ar_i) + 48'(zrs)), srfft_pkg::sat(48'(ai_i) + 48'(zis))};
    dif_o = {srfft_pkg::sat(48'(ar_i) - 48'(zrs)), srfft_pkg::sat(48'(ai_i) - 48'(zis))};
  end
endmodule

// File: dv/stockham_radix2_fft_tb.sv
// Self-checking testbench for stockham_radix2_fft: random frames at several sizes,
// bins predicted by a fixed-point Stockham model and compared in order.
// Depends on srfft_pkg and the RTL of the block.
module stockham_radix2_fft_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } sample_t;

  typedef struct packed {
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic [5:0]         idx;
    logic               last;
  } bin_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_data_i = 3'd6;
  logic sample_valid_i = 1'b0;
  logic sample_stall_o;
  logic signed [15:0] sample_real_i = '0;
  logic signed [15:0] sample_imag_i = '0;
  logic bin_valid_o;
  logic bin_stall_i = 1'b0;
  logic signed [23:0] bin_real_o;
  logic signed [23:0] bin_imag_o;
  logic [5:0] bin_index_o;
  logic last_bin_o;

  stockham_radix2_fft u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .sample_valid_i, .sample_stall_o,
    .sample_real_i, .sample_imag_i, .bin_valid_o, .bin_stall_i, .bin_real_o,
    .bin_imag_o, .bin_index_o, .last_bin_o
  );

  localparam int IdleLimit = 20000;

  sample_t pending_samples[$];
  bin_t    expected_bins[$];
  logic signed [23:0] frame_re[64];
  logic signed [23:0] frame_im[64];
  int  fill_count = 0;
  int  size_log = 6;
  int  errors = 0;
  int  bins_seen = 0;
  int  samples_sent = 0;
  int  frames_done = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;

  always #5 clk_i = ~clk_i;

  function automatic longint sat24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint rnd15(input longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic int cos_q(input int k);
    int t;
    t = (k <= 16) ? k : 32 - k;
    t = (t == 0) ? 32767 : $rtoi($floor(32768.0 * $cos(3.14159265358979 * t / 32.0) + 0.5));
    return (k <= 16) ? t : -t;
  endfunction

  function automatic int sin_q(input int k);
    int t;
    t = (k <= 16) ? 16 - k : k - 16;
    return (t == 0) ? 32768 : $rtoi($floor(32768.0 * $cos(3.14159265358979 * t / 32.0) + 0.5));
  endfunction

  task automatic transform_frame();
    longint ar[64], ai[64], br[64], bi[64];
    longint xr, xi, yr, yi, zr, zi, wr, wi;
    int n, p, h, k, ia, ib, oe;
    bin_t b;
    n = 1 << size_log;
    for (int i = 0; i < 64; i++) begin
      ar[i] = frame_re[i];
      ai[i] = frame_im[i];
    end
    for (int s = 1; s <= size_log; s++) begin
      p = 1 << s;
      h = p / 2;
      for (int g = 0; g < n / p; g++) begin
        for (int j = 0; j < h; j++) begin
          ia = g * h + j;
          ib = ia + n / 2;
          oe = g * p + j;
          k = (j * (64 >> s)) & 31;
          wr = cos_q(k);
          wi = -sin_q(k);
          xr = ar[ia]; xi = ai[ia]; yr = ar[ib]; yi = ai[ib];
          zr = sat24(rnd15(wr * yr - wi * yi));
          zi = sat24(rnd15(wr * yi + wi * yr));
          br[oe] = sat24(xr + zr);
          bi[oe] = sat24(xi + zi);
          br[oe + h] = sat24(xr - zr);
          bi[oe + h] = sat24(xi - zi);
        end
      end
      ar = br;
      ai = bi;
    end
    for (int i = 0; i < n; i++) begin
      b.re = ar[i][23:0];
      b.im = ai[i][23:0];
      b.idx = i[5:0];
      b.last = (i == n - 1);
      expected_bins.push_back(b);
    end
    frames_done++;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && !(sample_valid_i && sample_stall_o)) begin
      if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
        sample_valid_i <= 1'b1;
        sample_real_i <= pending_samples[0].re;
        sample_imag_i <= pending_samples[0].im;
        void'(pending_samples.pop_front());
      end else begin
        sample_valid_i <= 1'b0;
      end
    end
    bin_stall_i <= !calm && ($urandom_range(99) < 38);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles = idle_cycles + 1;
      if (sample_valid_i && !sample_stall_o) begin
        idle_cycles = 0;
        samples_sent++;
        frame_re[fill_count] = sample_real_i;
        frame_im[fill_count] = sample_imag_i;
        fill_count++;
        if (fill_count == (1 << size_log)) begin
          fill_count = 0;
          transform_frame();
        end
      end
      if (bin_valid_o && !bin_stall_i) begin
        bin_t e;
        idle_cycles = 0;
        bins_seen++;
        if (expected_bins.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected bin %0d re %0d im %0d", bin_index_o,
                                     bin_real_o, bin_imag_o);
        end else begin
          e = expected_bins.pop_front();
          if (bin_real_o !== e.re || bin_imag_o !== e.im || bin_index_o !== e.idx ||
              last_bin_o !== e.last) begin
            errors++;
            if (errors <= 10)
              $display("bin mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                       e.re, e.im, e.idx, e.last, bin_real_o, bin_imag_o,
                       bin_index_o, last_bin_o);
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no transfer for %0d cycles", IdleLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic sample_t rand_sample(input int kind);
    sample_t s;
    s.re = 16'($urandom);
    s.im = 16'($urandom);
    if (kind == 1) begin
      s.re = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      s.im = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end else if (kind == 2) begin
      s.re = $signed(16'($urandom_range(200))) - 16'sd100;
      s.im = $signed(16'($urandom_range(200))) - 16'sd100;
    end
    return s;
  endfunction

  task automatic run_frames(input int lg, input int frames, input int kind);
    wait (pending_samples.size() == 0 && expected_bins.size() == 0 && !sample_valid_i);
    repeat (2 * 64 * 6 + 20) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_data_i = lg[2:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    size_log = (lg < 1) ? 1 : ((lg > 6) ? 6 : lg);
    for (int f = 0; f < frames; f++)
      for (int i = 0; i < (1 << size_log); i++) pending_samples.push_back(rand_sample(kind));
  endtask

  initial begin
    sample_t s;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: an impulse with extreme values at reset size
    s.re = 16'sh7fff; s.im = 16'sh8000;
    pending_samples.push_back(s);
    s = '0;
    for (int i = 1; i < 64; i++) pending_samples.push_back(s);
    run_frames(0, 2, 1);
    run_frames(1, 2, 0);
    run_frames(7, 1, 1);
    run_frames(2, 4, 2);
    calm = 1'b1;
    run_frames(3, 3, 0);
    calm = 1'b0;
    run_frames(4, 1, 0);
    run_frames(5, 1, 0);
    run_frames(2, 2, 0);
    wait (pending_samples.size() == 0 && expected_bins.size() == 0 && !sample_valid_i);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d samples in %0d frames, checked %0d bins", samples_sent,
             frames_done, bins_seen);
    $display("Sizes 2 to 64 points, out-of-range size codes, random stalls on both sides");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
